/* hw/rtl/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP response parser package
// Shared types, character codes, event codes and header name tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hrsp_pkg;

  localparam int unsigned LEN_BITS = 40;

  localparam logic [LEN_BITS-1:0] LEN_MAX   = '1;
  localparam logic [LEN_BITS-1:0] LEN_DIV10 = LEN_MAX / 10;
  localparam logic [3:0]          LEN_REM10 = 4'(LEN_MAX % 10);

  localparam logic [9:0] STATUS_OK  = 10'd200;
  localparam logic [9:0] STATUS_MAX = 10'd999;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_STATUS = 3'd0,
    PH_NAME   = 3'd1,
    PH_VALUE  = 3'd2,
    PH_BODY   = 3'd3,
    PH_CSIZE  = 3'd4,
    PH_CDATA  = 3'd5,
    PH_DONE   = 3'd6,
    PH_REJECT = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    VK_OTHER  = 2'd0,
    VK_TYPE   = 2'd1,
    VK_ETAG   = 2'd2,
    VK_LENGTH = 2'd3
  } value_kind_e;

  typedef enum logic [2:0] {
    EV_TYPE_BYTE  = 3'd0,
    EV_TYPE_END   = 3'd1,
    EV_ETAG_BYTE  = 3'd2,
    EV_ETAG_END   = 3'd3,
    EV_HEADER_END = 3'd4,
    EV_BODY_BYTE  = 3'd5,
    EV_BODY_END   = 3'd6,
    EV_REJECT     = 3'd7
  } event_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_response;
  } in_item_t;

  // The results of one input item. A second result is always a body end.
  typedef struct packed {
    logic                two;
    event_e              ev;
    logic [7:0]          val;
    logic [9:0]          status;
    logic [LEN_BITS-1:0] clen;
    logic                chunked;
  } res_bundle_t;

  function automatic logic [7:0] etag_char(logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = "e";
      2'd1: ch = "t";
      2'd2: ch = "a";
      default: ch = "g";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] clen_char(logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = "c";
      4'd1:  ch = "o";
      4'd2:  ch = "n";
      4'd3:  ch = "t";
      4'd4:  ch = "e";
      4'd5:  ch = "n";
      4'd6:  ch = "t";
      4'd7:  ch = "-";
      4'd8:  ch = "l";
      4'd9:  ch = "e";
      4'd10: ch = "n";
      4'd11: ch = "g";
      4'd12: ch = "t";
      4'd13: ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ctype_char(logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = "c";
      4'd1:  ch = "o";
      4'd2:  ch = "n";
      4'd3:  ch = "t";
      4'd4:  ch = "e";
      4'd5:  ch = "n";
      4'd6:  ch = "t";
      4'd7:  ch = "-";
      4'd8:  ch = "t";
      4'd9:  ch = "y";
      4'd10: ch = "p";
      4'd11: ch = "e";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(logic [7:0] ch);
    logic [4:0] r;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hrsp_in_if.sv */
// ----------------------------------------------------------------------------
// HTTP response parser input channel
// Valid/ready channel that carries one response byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_response;

  modport source(output valid, output data_byte, output new_response, input ready);
  modport sink(input valid, input data_byte, input new_response, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hrsp_out_if.sv */
// ----------------------------------------------------------------------------
// HTTP response parser result channel
// Valid/ready channel that carries one parser event per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrsp_out_if
  import hrsp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          event_res;
  logic [7:0]          value_byte;
  logic [9:0]          status_code;
  logic [LEN_BITS-1:0] content_length;
  logic                is_chunked;
  logic                last;

  modport source(output valid, output event_res, output value_byte, output status_code,
                 output content_length, output is_chunked, output last, input ready);
  modport sink(input valid, input event_res, input value_byte, input status_code,
               input content_length, input is_chunked, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hrsp_in_stage.sv */
// ----------------------------------------------------------------------------
// HTTP response parser input register
// Holds one accepted byte until the parser step takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrsp_in_stage
  import hrsp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_item_t item_i,
  output logic          valid_o,
  input  wire logic     take_i,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/hrsp_step.sv */
// ----------------------------------------------------------------------------
// HTTP response parser step
// Parser state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module hrsp_step
  import hrsp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire in_item_t item_i,
  output logic          push_o,
  output res_bundle_t   res_o
);

  phase_e              phase_q, phase_d, phase_b;
  value_kind_e         vk_q, vk_d, vk_b;
  logic [1:0]          sc_q, sc_d, sc_b;
  logic [9:0]          st_q, st_d, st_b;
  logic                cr_q, cr_d, cr_b;
  logic                le_q, le_d, le_b;
  logic [3:0]          nl_q, nl_d, nl_b;
  logic [2:0]          nm_q, nm_d, nm_b;
  logic                skip_q, skip_d, skip_b;
  logic [LEN_BITS-1:0] la_q, la_d, la_b;
  logic                lk_q, lk_d, lk_b;
  logic [LEN_BITS-1:0] bl_q, bl_d, bl_b;

  logic [7:0]          ch;
  logic [7:0]          lc;
  logic                eol;
  logic [3:0]          dig;
  logic                is_dig;
  logic [4:0]          hex;
  logic [13:0]         st_mul;
  logic [LEN_BITS-1:0] la_mul;
  logic                la_sat;
  logic [LEN_BITS-1:0] bl_dec;
  logic [1:0]          n_res;

  assign ch     = item_i.data_byte;
  assign lc     = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
  assign eol    = (ch == CH_CR) || (ch == CH_LF);
  assign dig    = ch[3:0];
  assign is_dig = (ch >= "0") && (ch <= "9");
  assign hex    = hex_val(ch);

  // A new response starts from the reset state before its first byte.
  assign phase_b = item_i.new_response ? PH_STATUS : phase_q;
  assign vk_b    = item_i.new_response ? VK_OTHER : vk_q;
  assign sc_b    = item_i.new_response ? 2'd0 : sc_q;
  assign st_b    = item_i.new_response ? 10'd0 : st_q;
  assign cr_b    = item_i.new_response ? 1'b0 : cr_q;
  assign le_b    = item_i.new_response ? 1'b1 : le_q;
  assign nl_b    = item_i.new_response ? 4'd0 : nl_q;
  assign nm_b    = item_i.new_response ? 3'b111 : nm_q;
  assign skip_b  = item_i.new_response ? 1'b0 : skip_q;
  assign la_b    = item_i.new_response ? '0 : la_q;
  assign lk_b    = item_i.new_response ? 1'b0 : lk_q;
  assign bl_b    = item_i.new_response ? '0 : bl_q;

  assign st_mul = ({4'd0, st_b} << 3) + ({4'd0, st_b} << 1) + {10'd0, dig};
  assign la_mul = {la_b[LEN_BITS-4:0], 3'b000} + {la_b[LEN_BITS-2:0], 1'b0}
                + {{(LEN_BITS-4){1'b0}}, dig};
  assign la_sat = (la_b > LEN_DIV10) || ((la_b == LEN_DIV10) && (dig > LEN_REM10));
  assign bl_dec = (bl_b != '0) ? bl_b - 1'b1 : bl_b;

  always_comb begin
    phase_d = phase_b;
    vk_d    = vk_b;
    sc_d    = sc_b;
    st_d    = st_b;
    cr_d    = cr_b;
    le_d    = le_b;
    nl_d    = nl_b;
    nm_d    = nm_b;
    skip_d  = skip_b;
    la_d    = la_b;
    lk_d    = lk_b;
    bl_d    = bl_b;
    n_res   = 2'd0;
    res_o.ev      = EV_TYPE_BYTE;
    res_o.val     = 8'd0;
    res_o.clen    = '0;
    res_o.chunked = 1'b0;

    if (phase_b == PH_DONE || phase_b == PH_REJECT) begin
      n_res = 2'd0;
    end else if (skip_b) begin
      skip_d = 1'b0;
    end else if (cr_b && ch == CH_LF) begin
      cr_d = 1'b0;
    end else begin
      cr_d = 1'b0;
      case (phase_b)
        PH_STATUS: begin
          if (ch == CH_LF) begin
            if (sc_b == 2'd2) begin
              phase_d = PH_NAME;
              le_d    = 1'b1;
              nl_d    = 4'd0;
              nm_d    = 3'b111;
            end else begin
              st_d     = 10'd0;
              n_res    = 2'd1;
              res_o.ev = EV_REJECT;
              phase_d  = PH_REJECT;
            end
          end else if (ch == CH_SP) begin
            if (sc_b == 2'd0) begin
              sc_d = 2'd1;
            end else if (sc_b != 2'd2) begin
              sc_d = 2'd2;
              if (st_b != STATUS_OK) begin
                n_res    = 2'd1;
                res_o.ev = EV_REJECT;
                phase_d  = PH_REJECT;
              end
            end
          end else if (sc_b == 2'd1) begin
            if (is_dig) begin
              st_d = (st_b > 10'd99 || st_mul > 14'(STATUS_MAX)) ? STATUS_MAX : st_mul[9:0];
            end else begin
              sc_d = 2'd3;
            end
          end
        end
        PH_NAME: begin
          if (eol) begin
            cr_d = (ch == CH_CR);
            if (le_b) begin
              n_res         = 2'd1;
              res_o.ev      = EV_HEADER_END;
              res_o.clen    = lk_b ? la_b : '0;
              res_o.chunked = !lk_b;
              if (lk_b) begin
                if (la_b == '0) begin
                  n_res   = 2'd2;
                  phase_d = PH_DONE;
                end else begin
                  bl_d    = la_b;
                  phase_d = PH_BODY;
                end
              end else begin
                bl_d    = '0;
                sc_d    = 2'd0;
                le_d    = 1'b1;
                phase_d = PH_CSIZE;
              end
            end else begin
              le_d = 1'b1;
              nl_d = 4'd0;
              nm_d = 3'b111;
            end
          end else if (ch == CH_COLON) begin
            le_d = 1'b0;
            if (nl_b == 4'd4 && nm_b[0]) begin
              vk_d = VK_ETAG;
            end else if (nl_b == 4'd14 && nm_b[1]) begin
              vk_d = VK_LENGTH;
              la_d = '0;
              sc_d = 2'd0;
            end else if (nl_b == 4'd12 && nm_b[2]) begin
              vk_d = VK_TYPE;
            end else begin
              vk_d = VK_OTHER;
            end
            skip_d  = 1'b1;
            phase_d = PH_VALUE;
          end else begin
            le_d = 1'b0;
            if (nl_b >= 4'd4 || etag_char(nl_b[1:0]) != lc) begin
              nm_d[0] = 1'b0;
            end
            if (nl_b >= 4'd14 || clen_char(nl_b) != lc) begin
              nm_d[1] = 1'b0;
            end
            if (nl_b >= 4'd12 || ctype_char(nl_b) != lc) begin
              nm_d[2] = 1'b0;
            end
            if (nl_b != 4'd15) begin
              nl_d = nl_b + 4'd1;
            end
          end
        end
        PH_VALUE: begin
          if (eol) begin
            cr_d = (ch == CH_CR);
            if (vk_b == VK_TYPE) begin
              n_res    = 2'd1;
              res_o.ev = EV_TYPE_END;
            end else if (vk_b == VK_ETAG) begin
              n_res    = 2'd1;
              res_o.ev = EV_ETAG_END;
            end else if (vk_b == VK_LENGTH) begin
              lk_d = 1'b1;
            end
            phase_d = PH_NAME;
            le_d    = 1'b1;
            nl_d    = 4'd0;
            nm_d    = 3'b111;
          end else if (vk_b == VK_TYPE) begin
            n_res     = 2'd1;
            res_o.ev  = EV_TYPE_BYTE;
            res_o.val = ch;
          end else if (vk_b == VK_ETAG) begin
            n_res     = 2'd1;
            res_o.ev  = EV_ETAG_BYTE;
            res_o.val = ch;
          end else if (vk_b == VK_LENGTH) begin
            if (sc_b == 2'd0 && (ch == CH_SP || ch == CH_TAB)) begin
              sc_d = sc_b;
            end else if (sc_b < 2'd2 && is_dig) begin
              la_d = la_sat ? LEN_MAX : la_mul;
              sc_d = 2'd1;
            end else begin
              sc_d = 2'd2;
            end
          end
        end
        PH_BODY: begin
          n_res     = 2'd1;
          res_o.ev  = EV_BODY_BYTE;
          res_o.val = ch;
          bl_d      = bl_dec;
          if (bl_dec == '0) begin
            n_res   = 2'd2;
            phase_d = PH_DONE;
          end
        end
        PH_CSIZE: begin
          if (eol) begin
            cr_d = (ch == CH_CR);
            if (!le_b) begin
              if (bl_b == '0) begin
                n_res    = 2'd1;
                res_o.ev = EV_BODY_END;
                phase_d  = PH_DONE;
              end else begin
                phase_d = PH_CDATA;
              end
            end
            le_d = 1'b1;
            sc_d = 2'd0;
          end else begin
            le_d = 1'b0;
            if (sc_b == 2'd0 && hex[4]) begin
              bl_d = (bl_b[LEN_BITS-1 -: 4] != 4'd0) ? LEN_MAX
                   : {bl_b[LEN_BITS-5:0], hex[3:0]};
            end else begin
              sc_d = 2'd2;
            end
          end
        end
        PH_CDATA: begin
          n_res     = 2'd1;
          res_o.ev  = EV_BODY_BYTE;
          res_o.val = ch;
          bl_d      = bl_dec;
          if (bl_dec == '0) begin
            phase_d = PH_CSIZE;
            le_d    = 1'b1;
            sc_d    = 2'd0;
          end
        end
        default: begin
          phase_d = PH_REJECT;
        end
      endcase
    end

    res_o.two    = (n_res == 2'd2);
    res_o.status = st_d;
  end

  assign push_o = en_i && (n_res != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STATUS;
      vk_q    <= VK_OTHER;
      sc_q    <= 2'd0;
      st_q    <= 10'd0;
      cr_q    <= 1'b0;
      le_q    <= 1'b1;
      nl_q    <= 4'd0;
      nm_q    <= 3'b111;
      skip_q  <= 1'b0;
      la_q    <= '0;
      lk_q    <= 1'b0;
      bl_q    <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      vk_q    <= vk_d;
      sc_q    <= sc_d;
      st_q    <= st_d;
      cr_q    <= cr_d;
      le_q    <= le_d;
      nl_q    <= nl_d;
      nm_q    <= nm_d;
      skip_q  <= skip_d;
      la_q    <= la_d;
      lk_q    <= lk_d;
      bl_q    <= bl_d;
    end
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !item_i.new_response && (phase_q == PH_DONE || phase_q == PH_REJECT))
    |-> !push_o)
    else $error("finished response produced a result");

  a_two_ends_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.two) |=> (phase_q == PH_DONE))
    else $error("second result without reaching the end of the body");

  a_skip_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && skip_q && !item_i.new_response) |=> !skip_q)
    else $error("dropped byte flag held for more than one byte");

endmodule

`default_nettype wire

/* hw/rtl/hrsp_out_queue.sv */
// ----------------------------------------------------------------------------
// HTTP response parser result queue
// Two-entry queue of per-byte result bundles, sent out one event at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module hrsp_out_queue
  import hrsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire res_bundle_t res_i,
  output logic             room_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [2:0]       event_o,
  output logic [7:0]       value_o,
  output logic [9:0]       status_o,
  output logic [LEN_BITS-1:0] clen_o,
  output logic             chunked_o,
  output logic             last_o
);

  res_bundle_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        sub_q, sub_d;
  res_bundle_t head;
  logic        fire;
  logic        pop;

  assign head    = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign last_o  = sub_q || !head.two;
  assign fire    = valid_o && ready_i;
  assign pop     = fire && last_o;

  assign event_o   = sub_q ? EV_BODY_END : head.ev;
  assign value_o   = sub_q ? 8'd0 : head.val;
  assign status_o  = head.status;
  assign clen_o    = sub_q ? '0 : head.clen;
  assign chunked_o = sub_q ? 1'b0 : head.chunked;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
    sub_d    = sub_q;
    if (fire) begin
      sub_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      sub_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      sub_q    <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2))
    else $error("result bundle pushed into a full queue");

  a_sub_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (valid_o && head.two))
    else $error("second event selected on a single-result bundle");

  a_pair_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> (sub_q && valid_o))
    else $error("second event of a pair lost");

endmodule

`default_nettype wire

/* hw/rtl/http_response_stream_parser.sv */
// ----------------------------------------------------------------------------
// HTTP response stream parser
// Parses an HTTP/1.1 response one byte per item and emits header and body
// events.
// Each taken byte is held in the input register, and the step logic writes
// its results into the result queue, from which the events are sent out.
// Throughput: one byte per cycle while the result queue has room; a byte
// with two results sends two events, and the two-entry queue can then stall the input.
// Reset: asynchronous, clears the parser state and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_stream_parser
  import hrsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrsp_in_if.sink   in_i,
  hrsp_out_if.source out_o
);

  in_item_t    in_item;
  in_item_t    stage_item;
  logic        stage_valid;
  logic        step_en;
  logic        room;
  logic        push;
  res_bundle_t res;

  assign in_item.data_byte    = in_i.data_byte;
  assign in_item.new_response = in_i.new_response;
  assign step_en              = stage_valid && room;

  hrsp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (step_en),
    .item_o  (stage_item)
  );

  hrsp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (stage_item),
    .push_o (push),
    .res_o  (res)
  );

  hrsp_out_queue u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res_i     (res),
    .room_o    (room),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .event_o   (out_o.event_res),
    .value_o   (out_o.value_byte),
    .status_o  (out_o.status_code),
    .clen_o    (out_o.content_length),
    .chunked_o (out_o.is_chunked),
    .last_o    (out_o.last)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// HTTP response stream parser testbench
// Feeds generated HTTP/1.1 responses byte by byte, with status lines, headers
// in mixed case, fixed-length and chunked bodies, broken lines and noise,
// predicts the parser events in a behavioral model of the parser and checks
// every event field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import hrsp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int STREAM_BYTES = 1950;

  localparam logic [8*4-1:0]  NAME_ETAG  = "etag";
  localparam logic [8*14-1:0] NAME_CLEN  = "content-length";
  localparam logic [8*12-1:0] NAME_CTYPE = "content-type";

  typedef struct packed {
    event_e              ev;
    logic [7:0]          val;
    logic [9:0]          status;
    logic [LEN_BITS-1:0] clen;
    logic                chunked;
    logic                last;
  } parser_event_t;

  logic clk_i;
  logic rst_ni;

  hrsp_in_if  in_if ();
  hrsp_out_if out_if ();

  http_response_stream_parser u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  in_item_t      byte_stream[$];
  parser_event_t expected_events[$];
  parser_event_t byte_events[$];
  bit            mark_new;
  int            total_bytes;
  int            bytes_taken;
  int            responses;
  int            events_checked;
  int            mismatch_cnt;
  int            quiet_cycles;
  int            event_tally[8];
  in_item_t      next_item;

  phase_e              ps_phase;
  logic [1:0]          ps_spaces;
  logic [9:0]          ps_status;
  logic                ps_cr;
  logic                ps_line_empty;
  logic [3:0]          ps_name_len;
  logic [2:0]          ps_match;
  value_kind_e         ps_kind;
  logic                ps_skip;
  logic [LEN_BITS-1:0] ps_len;
  logic                ps_len_known;
  logic [LEN_BITS-1:0] ps_left;

  function automatic void clear_parser();
    ps_phase      = PH_STATUS;
    ps_spaces     = '0;
    ps_status     = '0;
    ps_cr         = 1'b0;
    ps_line_empty = 1'b1;
    ps_name_len   = '0;
    ps_match      = 3'b111;
    ps_kind       = VK_OTHER;
    ps_skip       = 1'b0;
    ps_len        = '0;
    ps_len_known  = 1'b0;
    ps_left       = '0;
  endfunction

  function automatic void start_line();
    ps_line_empty = 1'b1;
    ps_name_len   = '0;
    ps_match      = 3'b111;
  endfunction

  function automatic void add_event(event_e ev, logic [7:0] val, logic [LEN_BITS-1:0] clen,
                                    logic chunked);
    parser_event_t e;
    if (byte_events.size() < 2) begin
      e.ev      = ev;
      e.val     = val;
      e.status  = ps_status;
      e.clen    = clen;
      e.chunked = chunked;
      e.last    = 1'b0;
      byte_events = {byte_events, e};
    end
  endfunction

  function automatic logic [LEN_BITS-1:0] dec_step(logic [LEN_BITS-1:0] acc, logic [3:0] d);
    logic [63:0] wide;
    if (64'(acc) > (64'(LEN_MAX) - 64'(d)) / 64'd10) return LEN_MAX;
    wide = 64'(acc) * 64'd10 + 64'(d);
    return wide[LEN_BITS-1:0];
  endfunction

  function automatic logic [LEN_BITS-1:0] hex_step(logic [LEN_BITS-1:0] acc, logic [3:0] d);
    logic [63:0] wide;
    if (64'(acc) > ((64'(LEN_MAX) - 64'(d)) >> 4)) return LEN_MAX;
    wide = (64'(acc) << 4) + 64'(d);
    return wide[LEN_BITS-1:0];
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic void match_name_char(logic [7:0] c);
    logic [7:0] lc;
    int         n;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    n  = ps_name_len;
    if (n >= 4) ps_match[0] = 1'b0;
    else if (NAME_ETAG[8*(3-n) +: 8] != lc) ps_match[0] = 1'b0;
    if (n >= 14) ps_match[1] = 1'b0;
    else if (NAME_CLEN[8*(13-n) +: 8] != lc) ps_match[1] = 1'b0;
    if (n >= 12) ps_match[2] = 1'b0;
    else if (NAME_CTYPE[8*(11-n) +: 8] != lc) ps_match[2] = 1'b0;
    if (ps_name_len < 4'd15) ps_name_len = ps_name_len + 4'd1;
  endfunction

  function automatic void finish_headers();
    add_event(EV_HEADER_END, 8'h00, ps_len_known ? ps_len : '0, !ps_len_known);
    if (ps_len_known) begin
      if (ps_len == '0) begin
        add_event(EV_BODY_END, 8'h00, '0, 1'b0);
        ps_phase = PH_DONE;
      end else begin
        ps_left  = ps_len;
        ps_phase = PH_BODY;
      end
    end else begin
      ps_left       = '0;
      ps_spaces     = '0;
      ps_line_empty = 1'b1;
      ps_phase      = PH_CSIZE;
    end
  endfunction

  function automatic void parse_byte(in_item_t it);
    logic [7:0]    c;
    logic          eol;
    int            v;
    int            h;
    c   = it.data_byte;
    eol = (c == CH_CR || c == CH_LF);
    byte_events.delete();
    if (it.new_response) clear_parser();
    if (ps_phase == PH_DONE || ps_phase == PH_REJECT) return;
    if (ps_skip) begin
      ps_skip = 1'b0;
      return;
    end
    if (ps_cr) begin
      ps_cr = 1'b0;
      if (c == CH_LF) return;
    end
    case (ps_phase)
      PH_STATUS: begin
        if (c == CH_LF) begin
          if (ps_spaces == 2'd2) begin
            ps_phase = PH_NAME;
            start_line();
          end else begin
            ps_status = '0;
            add_event(EV_REJECT, 8'h00, '0, 1'b0);
            ps_phase = PH_REJECT;
          end
        end else if (c == CH_SP) begin
          if (ps_spaces == 2'd0) begin
            ps_spaces = 2'd1;
          end else if (ps_spaces != 2'd2) begin
            ps_spaces = 2'd2;
            if (ps_status != STATUS_OK) begin
              add_event(EV_REJECT, 8'h00, '0, 1'b0);
              ps_phase = PH_REJECT;
            end
          end
        end else if (ps_spaces == 2'd1) begin
          if (c >= "0" && c <= "9") begin
            v = int'(ps_status) * 10 + int'(c) - 48;
            ps_status = (ps_status > 10'd99 || v > 999) ? STATUS_MAX : 10'(v);
          end else begin
            ps_spaces = 2'd3;
          end
        end
      end
      PH_NAME: begin
        if (eol) begin
          ps_cr = (c == CH_CR);
          if (ps_line_empty) finish_headers();
          else start_line();
        end else if (c == CH_COLON) begin
          ps_line_empty = 1'b0;
          if (ps_name_len == 4'd4 && ps_match[0]) ps_kind = VK_ETAG;
          else if (ps_name_len == 4'd14 && ps_match[1]) ps_kind = VK_LENGTH;
          else if (ps_name_len == 4'd12 && ps_match[2]) ps_kind = VK_TYPE;
          else ps_kind = VK_OTHER;
          if (ps_kind == VK_LENGTH) begin
            ps_len    = '0;
            ps_spaces = '0;
          end
          ps_skip  = 1'b1;
          ps_phase = PH_VALUE;
        end else begin
          ps_line_empty = 1'b0;
          match_name_char(c);
        end
      end
      PH_VALUE: begin
        if (eol) begin
          ps_cr = (c == CH_CR);
          case (ps_kind)
            VK_TYPE:   add_event(EV_TYPE_END, 8'h00, '0, 1'b0);
            VK_ETAG:   add_event(EV_ETAG_END, 8'h00, '0, 1'b0);
            VK_LENGTH: ps_len_known = 1'b1;
            default: begin
            end
          endcase
          ps_phase = PH_NAME;
          start_line();
        end else begin
          case (ps_kind)
            VK_TYPE: add_event(EV_TYPE_BYTE, c, '0, 1'b0);
            VK_ETAG: add_event(EV_ETAG_BYTE, c, '0, 1'b0);
            VK_LENGTH: begin
              if (ps_spaces == 2'd0 && (c == CH_SP || c == CH_TAB)) begin
              end else if (ps_spaces < 2'd2 && c >= "0" && c <= "9") begin
                ps_len    = dec_step(ps_len, c[3:0]);
                ps_spaces = 2'd1;
              end else begin
                ps_spaces = 2'd2;
              end
            end
            default: begin
            end
          endcase
        end
      end
      PH_BODY: begin
        add_event(EV_BODY_BYTE, c, '0, 1'b0);
        if (ps_left != '0) ps_left = ps_left - 1'b1;
        if (ps_left == '0) begin
          add_event(EV_BODY_END, 8'h00, '0, 1'b0);
          ps_phase = PH_DONE;
        end
      end
      PH_CSIZE: begin
        if (eol) begin
          ps_cr = (c == CH_CR);
          if (!ps_line_empty) begin
            if (ps_left == '0) begin
              add_event(EV_BODY_END, 8'h00, '0, 1'b0);
              ps_phase = PH_DONE;
            end else begin
              ps_phase = PH_CDATA;
            end
          end
          ps_line_empty = 1'b1;
          ps_spaces     = '0;
        end else begin
          h = hex_digit(c);
          ps_line_empty = 1'b0;
          if (ps_spaces == 2'd0 && h >= 0) ps_left = hex_step(ps_left, 4'(h));
          else ps_spaces = 2'd2;
        end
      end
      PH_CDATA: begin
        add_event(EV_BODY_BYTE, c, '0, 1'b0);
        if (ps_left != '0) ps_left = ps_left - 1'b1;
        if (ps_left == '0) begin
          ps_phase      = PH_CSIZE;
          ps_line_empty = 1'b1;
          ps_spaces     = '0;
        end
      end
      default: ps_phase = PH_REJECT;
    endcase
    if (byte_events.size() > 0) begin
      byte_events[byte_events.size() - 1].last = 1'b1;
    end
    expected_events = {expected_events, byte_events};
  endfunction

  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte    = b;
    it.new_response = mark_new;
    mark_new        = 1'b0;
    byte_stream     = {byte_stream, it};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_mixed_case(string s);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      push_byte(ch);
    end
  endfunction

  function automatic void push_random(int n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_filler(int n, bit any_byte);
    logic [7:0] b;
    repeat (n) begin
      do begin
        b = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
      end while (b == CH_CR || b == CH_LF);
      push_byte(b);
    end
  endfunction

  function automatic void push_line_end();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (pick < 9) begin
      push_byte(CH_LF);
    end else begin
      push_byte(CH_CR);
    end
  endfunction

  function automatic void push_after_colon();
    if ($urandom_range(0, 9) < 8) push_byte(CH_SP);
    else push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic string other_name(int k);
    case (k)
      0: return "host";
      1: return "x-etag";
      2: return "etags";
      3: return "content-len";
      4: return "content-lengthx";
      default: return "content-typ";
    endcase
  endfunction

  // Returns the body length the header announces, -2 for one too large to send.
  function automatic int push_length_value();
    int v;
    int pick;
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      v = $urandom_range(0, 16);
      push_text($sformatf("%0d", v));
    end else if (pick < 80) begin
      v = $urandom_range(0, 9);
      push_text($sformatf("%0d ;x", v));
    end else if (pick < 88) begin
      v = 0;
      push_text("00");
    end else if (pick < 93) begin
      v = 0;
      push_text("none");
    end else begin
      v = -2;
      if (pick < 96) begin
        push_byte(8'("1" + $urandom_range(0, 8)));
        repeat ($urandom_range(12, 24)) push_byte(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 98) begin
        push_text("1099511627775");
      end else begin
        push_text("1099511627776");
      end
    end
    return v;
  endfunction

  function automatic void push_chunks();
    int chunk_len;
    int pick;
    if ($urandom_range(0, 99) < 3) begin
      push_mixed_case("ffffffffffffffff");
      push_line_end();
      push_random($urandom_range(1, 8));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      chunk_len = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) push_byte("0");
      push_mixed_case($sformatf("%0h", chunk_len));
      if ($urandom_range(0, 4) == 0) push_text(";ext=1");
      push_line_end();
      push_random(chunk_len);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end else if (pick == 8) begin
        push_byte(CH_LF);
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) push_text("0");
    else if (pick < 9) push_text("000");
    else push_text(";end");
    push_line_end();
    if ($urandom_range(0, 3) == 0) begin
      push_text("trailer: v");
      push_line_end();
    end
    push_line_end();
  endfunction

  function automatic void make_response();
    int    pick;
    int    n;
    int    clen_plan;
    bit    ok;
    string code;
    mark_new = 1'b1;
    responses++;
    if ($urandom_range(0, 99) < 4) begin
      push_random($urandom_range(5, 30));
      return;
    end
    if ($urandom_range(0, 1)) push_text("HTTP/1.1");
    push_byte(CH_SP);
    pick = $urandom_range(0, 99);
    ok   = 1'b1;
    if (pick < 78) begin
      code = "200";
    end else if (pick < 82) begin
      code = "304";
      ok   = 1'b0;
    end else if (pick < 86) begin
      n    = $urandom_range(0, 999);
      code = $sformatf("%0d", n);
      ok   = (n == 200);
    end else if (pick < 89) begin
      code = "0200";
    end else if (pick < 92) begin
      code = "200a";
    end else if (pick < 95) begin
      code = "12345";
      ok   = 1'b0;
    end else if (pick < 98) begin
      code = "2x0";
      ok   = 1'b0;
    end else begin
      code = "200";
      ok   = 1'b0;
    end
    push_text(code);
    if (pick < 98) begin
      push_byte(CH_SP);
      if ($urandom_range(0, 1)) push_text("OK");
    end
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
    if (!ok) begin
      push_filler($urandom_range(0, 3), 1'b1);
      return;
    end
    clen_plan = -1;
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        push_mixed_case("etag");
        push_byte(CH_COLON);
        push_after_colon();
        push_filler($urandom_range(0, 10), $urandom_range(0, 9) == 0);
      end else if (pick < 40) begin
        push_mixed_case("content-type");
        push_byte(CH_COLON);
        push_after_colon();
        push_filler($urandom_range(0, 10), $urandom_range(0, 9) == 0);
      end else if (pick < 65) begin
        push_mixed_case("content-length");
        push_byte(CH_COLON);
        push_after_colon();
        clen_plan = push_length_value();
      end else if (pick < 80) begin
        push_mixed_case(other_name($urandom_range(0, 5)));
        push_byte(CH_COLON);
        push_after_colon();
        push_filler($urandom_range(0, 6), 1'b0);
      end else if (pick < 90) begin
        push_mixed_case("x-no-colon");
      end else begin
        push_filler($urandom_range(1, 12), 1'b1);
      end
      push_line_end();
    end
    push_line_end();
    if (clen_plan >= 0) push_random(clen_plan);
    else if (clen_plan == -2) push_random($urandom_range(1, 12));
    else push_chunks();
    if ($urandom_range(0, 4) == 0) push_random($urandom_range(1, 4));
  endfunction

  function automatic int pace_mode();
    if (total_bytes == 0) return 0;
    return bytes_taken * 4 / total_bytes;
  endfunction

  function automatic bit sender_waits();
    case (pace_mode())
      1: return $urandom_range(0, 99) < 45;
      3: return $urandom_range(0, 99) < 14;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace_mode())
      2: return $urandom_range(0, 99) < 45;
      3: return $urandom_range(0, 99) < 14;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_event();
    parser_event_t want;
    if (expected_events.size() == 0) begin
      $error("event_res: no event expected, got %0d", out_if.event_res);
      mismatch_cnt++;
      return;
    end
    want = expected_events.pop_front();
    events_checked++;
    event_tally[int'(want.ev)]++;
    if (out_if.event_res !== want.ev) begin
      $error("event_res: expected %0d, got %0d", want.ev, out_if.event_res);
      mismatch_cnt++;
    end
    if (out_if.value_byte !== want.val) begin
      $error("value_byte: expected %0d, got %0d", want.val, out_if.value_byte);
      mismatch_cnt++;
    end
    if (out_if.status_code !== want.status) begin
      $error("status_code: expected %0d, got %0d", want.status, out_if.status_code);
      mismatch_cnt++;
    end
    if (out_if.content_length !== want.clen) begin
      $error("content_length: expected %0d, got %0d", want.clen, out_if.content_length);
      mismatch_cnt++;
    end
    if (out_if.is_chunked !== want.chunked) begin
      $error("is_chunked: expected %0d, got %0d", want.chunked, out_if.is_chunked);
      mismatch_cnt++;
    end
    if (out_if.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_if.last);
      mismatch_cnt++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.data_byte    <= 8'h00;
      in_if.new_response <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        next_item.data_byte    = in_if.data_byte;
        next_item.new_response = in_if.new_response;
        parse_byte(next_item);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_stream.size() > 0 && !sender_waits()) begin
          next_item = byte_stream.pop_front();
          in_if.valid        <= 1'b1;
          in_if.data_byte    <= next_item.data_byte;
          in_if.new_response <= next_item.new_response;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_event();
      out_if.ready <= !receiver_stalls();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Timeout after %0d idle cycles, %0d events outstanding", quiet_cycles,
                   expected_events.size());
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.data_byte    = 8'h00;
    in_if.new_response = 1'b0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    clear_parser();

    // Shortest chunked response, an overflowing status code, a status line
    // without code, and extreme byte values ignored in the status line.
    mark_new = 1'b1;
    push_text(" 200 ");
    push_byte(CH_LF);
    push_byte(CH_LF);
    push_text("0");
    push_byte(CH_LF);
    mark_new = 1'b1;
    push_text(" 2000 x");
    push_byte(CH_LF);
    mark_new = 1'b1;
    push_byte(CH_LF);
    mark_new = 1'b1;
    push_byte(8'hFF);
    push_byte(8'h00);
    responses = 4;
    while (byte_stream.size() < STREAM_BYTES) make_response();
    total_bytes = byte_stream.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (bytes_taken == total_bytes);
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d bytes in %0d responses and checked %0d parser events.", total_bytes,
             responses, events_checked);
    $display("Header ends %0d, body bytes %0d, body ends %0d, rejects %0d, value bytes %0d.",
             event_tally[EV_HEADER_END], event_tally[EV_BODY_BYTE], event_tally[EV_BODY_END],
             event_tally[EV_REJECT], event_tally[EV_TYPE_BYTE] + event_tally[EV_ETAG_BYTE]);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/hrsp_pkg.sv
hw/rtl/hrsp_in_if.sv
hw/rtl/hrsp_out_if.sv
hw/rtl/hrsp_in_stage.sv
hw/rtl/hrsp_step.sv
hw/rtl/hrsp_out_queue.sv
hw/rtl/http_response_stream_parser.sv
tb/testbench.sv
